@@ design/hpt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpt_pkg: shared types and constants of the heading position tracker
// Holds the command codes, the field widths, the heading reduction constants
// and the quarter-wave sine table in Q1.15.
// ----------------------------------------------------------------------------
package hpt_pkg;

    localparam int VALUE_W   = 16;
    localparam int POS_W     = 48;
    localparam int HEIGHT_W  = 16;
    localparam int HEADING_W = 9;
    localparam int REM_W     = 7;
    localparam int TRIG_W    = 16;

    typedef enum logic [1:0] {
        CMD_HEIGHT  = 2'd0,
        CMD_TURN    = 2'd1,
        CMD_MOVE    = 2'd2,
        CMD_INVALID = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        QUAD_I   = 2'd0,
        QUAD_II  = 2'd1,
        QUAD_III = 2'd2,
        QUAD_IV  = 2'd3
    } quad_t;

    // Heading kept both as whole degrees and split into quadrant and offset.
    typedef struct packed {
        logic [HEADING_W-1:0] degrees;
        quad_t                quad;
        logic [REM_W-1:0]     rem;
    } heading_t;

    // Magnitude and sign of one trig value.
    typedef struct packed {
        logic [TRIG_W-1:0] mag;
        logic              neg;
    } trig_t;

    localparam logic [HEADING_W-1:0] QUARTER_TURN    = 9'd90;
    localparam logic [HEADING_W-1:0] HALF_TURN       = 9'd180;
    localparam logic [HEADING_W-1:0] THREE_QUARTERS  = 9'd270;
    localparam logic [HEADING_W-1:0] FULL_TURN       = 9'd360;

    // The value is biased by 128 full turns so the reduction works on an
    // unsigned number; floor(u / 360) is then u * MOD_RECIP >> MOD_SHIFT.
    localparam logic [16:0] MOD_OFFSET = 17'd46080;
    localparam logic [16:0] MOD_RECIP  = 17'd93207;
    localparam int          MOD_SHIFT  = 25;

    localparam logic [TRIG_W-1:0] SINE_TABLE [0:90] = '{
        16'd0,     16'd572,   16'd1144,  16'd1715,  16'd2286,
        16'd2856,  16'd3425,  16'd3993,  16'd4560,  16'd5126,
        16'd5690,  16'd6252,  16'd6813,  16'd7371,  16'd7927,
        16'd8481,  16'd9032,  16'd9580,  16'd10126, 16'd10668,
        16'd11207, 16'd11743, 16'd12275, 16'd12803, 16'd13328,
        16'd13848, 16'd14365, 16'd14876, 16'd15384, 16'd15886,
        16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324,
        16'd18795, 16'd19261, 16'd19720, 16'd20174, 16'd20622,
        16'd21063, 16'd21498, 16'd21926, 16'd22348, 16'd22763,
        16'd23170, 16'd23571, 16'd23965, 16'd24351, 16'd24730,
        16'd25102, 16'd25466, 16'd25822, 16'd26170, 16'd26510,
        16'd26842, 16'd27166, 16'd27482, 16'd27789, 16'd28088,
        16'd28378, 16'd28660, 16'd28932, 16'd29197, 16'd29452,
        16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592,
        16'd30792, 16'd30983, 16'd31164, 16'd31336, 16'd31499,
        16'd31651, 16'd31795, 16'd31928, 16'd32052, 16'd32166,
        16'd32270, 16'd32365, 16'd32449, 16'd32524, 16'd32588,
        16'd32647, 16'd32688, 16'd32723, 16'd32748, 16'd32763,
        16'd32768
    };

    // Sine of a whole-degree angle in the first quadrant, Q1.15 magnitude.
    function automatic logic [TRIG_W-1:0] sine_lookup(input logic [REM_W-1:0] idx);
        logic [TRIG_W-1:0] result;
        begin
            if (idx > REM_W'(QUARTER_TURN))
            begin
                result = '0;
            end
            else
            begin
                result = SINE_TABLE[idx];
            end
            return result;
        end
    endfunction

endpackage

@@ design/heading_position_tracker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heading_position_tracker: craft position, height and heading tracker
// Applies one height, turn or move command per request and reports the
// updated state with every result.
// ----------------------------------------------------------------------------
// The tracker takes one command request per clock cycle while in_stall is
// low and returns exactly one result request for each, passing through the
// input register and then the state registers. A request first lands in an
// input register; once the result slot is empty or being drained, a single
// pass of logic (heading reduction by reciprocal multiply, quarter-wave table
// lookup, one 16x16 multiply per axis, a 49-bit saturating add) updates the
// state registers. The state registers are the result register: out_x,
// out_y, out_height and out_heading show the state after the most recent
// command and hold while the output is stalled, since the state only
// advances when the result slot is empty or being drained. Sustained rate is
// one item per cycle when out_stall is low, set by the state-register feedback.
// A turn sets the heading to the value modulo 360 (negative values wrap up).
// A height command adds a signed rise, clamped to 0..65535. A move adds
// distance*cos and distance*sin to x and y, only while height is nonzero;
// positions are signed with FRAC_BITS fraction bits and saturate at the
// 48-bit limits. Command code 3 raises bad_command and changes nothing.
// in_stall is high only while a request sits in the input register and the
// result slot is occupied and stalled.
// ----------------------------------------------------------------------------
module heading_position_tracker
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [1:0]                           command,
    input  logic signed [hpt_pkg::VALUE_W-1:0]   value,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [hpt_pkg::POS_W-1:0]     out_x,
    output logic signed [hpt_pkg::POS_W-1:0]     out_y,
    output logic [hpt_pkg::HEIGHT_W-1:0]         out_height,
    output logic [hpt_pkg::HEADING_W-1:0]        out_heading,
    output logic                                 bad_command
);

    // Input register.
    logic                                in_valid_reg, in_valid_next;
    hpt_pkg::cmd_t                       cmd_reg;
    logic signed [hpt_pkg::VALUE_W-1:0]  value_reg;

    // State, which doubles as the result register.
    logic signed [hpt_pkg::POS_W-1:0]    pos_x_reg, pos_x_next;
    logic signed [hpt_pkg::POS_W-1:0]    pos_y_reg, pos_y_next;
    logic [hpt_pkg::HEIGHT_W-1:0]        height_reg, height_next;
    logic [hpt_pkg::HEADING_W-1:0]       heading_reg, heading_next;
    hpt_pkg::quad_t                      quad_reg, quad_next;
    logic [hpt_pkg::REM_W-1:0]           rem_reg, rem_next;
    logic                                bad_reg, bad_next;
    logic                                out_valid_reg, out_valid_next;

    logic                                accept;
    logic                                advance;
    hpt_pkg::heading_t                   turn_heading;
    logic [hpt_pkg::TRIG_W-1:0]          mag_direct;
    logic [hpt_pkg::TRIG_W-1:0]          mag_compl;
    hpt_pkg::trig_t                      sin_val;
    hpt_pkg::trig_t                      cos_val;
    logic signed [hpt_pkg::POS_W-1:0]    moved_x;
    logic signed [hpt_pkg::POS_W-1:0]    moved_y;
    logic signed [hpt_pkg::HEIGHT_W+1:0] height_sum;
    logic [hpt_pkg::HEIGHT_W-1:0]        height_clamped;

    // Handshake: the held request moves into the result slot whenever that
    // slot is empty or being drained this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    assign in_valid_next  = accept || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            height_reg    <= '0;
            heading_reg   <= '0;
            quad_reg      <= hpt_pkg::QUAD_I;
            rem_reg       <= '0;
            bad_reg       <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            height_reg    <= height_next;
            heading_reg   <= heading_next;
            quad_reg      <= quad_next;
            rem_reg       <= rem_next;
            bad_reg       <= bad_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= hpt_pkg::cmd_t'(command);
            value_reg <= value;
        end
    end

    // Turn: reduce the requested heading modulo a full turn.
    hpt_heading u_heading
    (
        .value   (value_reg),
        .heading (turn_heading)
    );

    // Trig values from the stored quadrant and offset. Within a quadrant
    // one axis reads the table at the offset, the other at its complement.
    always_comb
    begin
        mag_direct = hpt_pkg::sine_lookup(rem_reg);
        mag_compl  = hpt_pkg::sine_lookup(hpt_pkg::REM_W'(hpt_pkg::QUARTER_TURN) - rem_reg);
        case (quad_reg)
            hpt_pkg::QUAD_I:
            begin
                sin_val = '{mag: mag_direct, neg: 1'b0};
                cos_val = '{mag: mag_compl,  neg: 1'b0};
            end
            hpt_pkg::QUAD_II:
            begin
                sin_val = '{mag: mag_compl,  neg: 1'b0};
                cos_val = '{mag: mag_direct, neg: 1'b1};
            end
            hpt_pkg::QUAD_III:
            begin
                sin_val = '{mag: mag_direct, neg: 1'b1};
                cos_val = '{mag: mag_compl,  neg: 1'b1};
            end
            default:
            begin
                sin_val = '{mag: mag_compl,  neg: 1'b1};
                cos_val = '{mag: mag_direct, neg: 1'b0};
            end
        endcase
    end

    hpt_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_x
    (
        .distance (value_reg),
        .trig     (cos_val),
        .pos      (pos_x_reg),
        .pos_next (moved_x)
    );

    hpt_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_y
    (
        .distance (value_reg),
        .trig     (sin_val),
        .pos      (pos_y_reg),
        .pos_next (moved_y)
    );

    // Height: signed rise, clamped to the unsigned height range.
    always_comb
    begin
        height_sum = $signed({2'b00, height_reg})
                   + $signed({{2{value_reg[hpt_pkg::VALUE_W-1]}}, value_reg});
        if (height_sum[hpt_pkg::HEIGHT_W+1])
        begin
            height_clamped = '0;
        end
        else if (height_sum[hpt_pkg::HEIGHT_W])
        begin
            height_clamped = '1;
        end
        else
        begin
            height_clamped = height_sum[hpt_pkg::HEIGHT_W-1:0];
        end
    end

    // State update, taken only when the request moves into the result slot.
    always_comb
    begin
        pos_x_next   = pos_x_reg;
        pos_y_next   = pos_y_reg;
        height_next  = height_reg;
        heading_next = heading_reg;
        quad_next    = quad_reg;
        rem_next     = rem_reg;
        bad_next     = bad_reg;
        if (advance)
        begin
            bad_next = 1'b0;
            case (cmd_reg)
                hpt_pkg::CMD_HEIGHT:
                begin
                    height_next = height_clamped;
                end
                hpt_pkg::CMD_TURN:
                begin
                    heading_next = turn_heading.degrees;
                    quad_next    = turn_heading.quad;
                    rem_next     = turn_heading.rem;
                end
                hpt_pkg::CMD_MOVE:
                begin
                    // A grounded craft does not move.
                    if (height_reg != '0)
                    begin
                        pos_x_next = moved_x;
                        pos_y_next = moved_y;
                    end
                end
                default:
                begin
                    bad_next = 1'b1;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_x       = pos_x_reg;
    assign out_y       = pos_y_reg;
    assign out_height  = height_reg;
    assign out_heading = heading_reg;
    assign bad_command = bad_reg;

    // The split heading always agrees with the whole-degree heading.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rem_reg < hpt_pkg::REM_W'(hpt_pkg::QUARTER_TURN)) &&
        (heading_reg == ({7'd0, quad_reg} * hpt_pkg::QUARTER_TURN + {2'd0, rem_reg})))
        else $error("split heading disagrees with heading register");

    // A rejected command changes no state.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (cmd_reg == hpt_pkg::CMD_INVALID)) |=>
        ($stable(pos_x_reg) && $stable(pos_y_reg) && $stable(height_reg) &&
         $stable(heading_reg) && bad_command))
        else $error("invalid command changed state");

    // A move while grounded leaves the position where it was.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (cmd_reg == hpt_pkg::CMD_MOVE) && (height_reg == '0)) |=>
        ($stable(pos_x_reg) && $stable(pos_y_reg)))
        else $error("position moved at zero height");

    // State only changes when a new result is produced.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!advance) |=> ($stable(pos_x_reg) && $stable(pos_y_reg) &&
                        $stable(height_reg) && $stable(heading_reg)))
        else $error("state changed without a result");

endmodule

@@ design/hpt_heading.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpt_heading: heading reduction
// Reduces a signed degree value to 0..359 and splits it into quadrant and
// offset within the quadrant.
// ----------------------------------------------------------------------------
module hpt_heading
(
    input  logic signed [hpt_pkg::VALUE_W-1:0] value,
    output hpt_pkg::heading_t                  heading
);

    logic [16:0]                    biased;
    logic [33:0]                    prod;
    logic [8:0]                     quot;
    logic [16:0]                    rem_full;
    logic [hpt_pkg::HEADING_W-1:0]  residue;

    always_comb
    begin
        biased   = {value[hpt_pkg::VALUE_W-1], value} + hpt_pkg::MOD_OFFSET;
        prod     = 34'(biased) * 34'(hpt_pkg::MOD_RECIP);
        quot     = prod[hpt_pkg::MOD_SHIFT +: 9];
        rem_full = biased - 17'(17'(quot) * 17'(hpt_pkg::FULL_TURN));
        // The reciprocal is exact over this range; the correction is a guard.
        if (rem_full >= 17'(hpt_pkg::FULL_TURN))
        begin
            rem_full = rem_full - 17'(hpt_pkg::FULL_TURN);
        end
        residue = rem_full[hpt_pkg::HEADING_W-1:0];

        heading.degrees = residue;
        if (residue >= hpt_pkg::THREE_QUARTERS)
        begin
            heading.quad = hpt_pkg::QUAD_IV;
            heading.rem  = hpt_pkg::REM_W'(residue - hpt_pkg::THREE_QUARTERS);
        end
        else if (residue >= hpt_pkg::HALF_TURN)
        begin
            heading.quad = hpt_pkg::QUAD_III;
            heading.rem  = hpt_pkg::REM_W'(residue - hpt_pkg::HALF_TURN);
        end
        else if (residue >= hpt_pkg::QUARTER_TURN)
        begin
            heading.quad = hpt_pkg::QUAD_II;
            heading.rem  = hpt_pkg::REM_W'(residue - hpt_pkg::QUARTER_TURN);
        end
        else
        begin
            heading.quad = hpt_pkg::QUAD_I;
            heading.rem  = hpt_pkg::REM_W'(residue);
        end
    end

endmodule

@@ design/hpt_axis.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpt_axis: one coordinate update
// Multiplies the distance by a trig value, scales the product to the position
// format and adds it to the coordinate with saturation.
// ----------------------------------------------------------------------------
module hpt_axis
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic signed [hpt_pkg::VALUE_W-1:0] distance,
    input  hpt_pkg::trig_t                     trig,
    input  logic signed [hpt_pkg::POS_W-1:0]   pos,
    output logic signed [hpt_pkg::POS_W-1:0]   pos_next
);

    localparam int SHL     = (FRAC_BITS >= 15) ? FRAC_BITS - 15 : 0;
    localparam int SHR     = (FRAC_BITS < 15) ? 15 - FRAC_BITS : 0;
    localparam int RND     = (SHR > 0) ? (1 << (SHR - 1)) : 0;
    localparam int PROD_W  = hpt_pkg::VALUE_W + hpt_pkg::TRIG_W;
    localparam int MAG_W   = PROD_W + SHL;
    localparam int DELTA_W = MAG_W + 1;
    localparam int POS_W   = hpt_pkg::POS_W;

    logic                      dist_neg;
    logic [hpt_pkg::VALUE_W-1:0] dist_mag;
    logic [PROD_W-1:0]         prod;
    logic [MAG_W-1:0]          scaled;
    logic signed [DELTA_W-1:0] delta;
    logic signed [POS_W:0]     sum;

    always_comb
    begin
        dist_neg = distance[hpt_pkg::VALUE_W-1];
        // The most negative distance maps to its unsigned magnitude exactly.
        dist_mag = dist_neg ? (~distance + 1'b1) : distance;
        prod     = PROD_W'(dist_mag) * PROD_W'(trig.mag);

        if (SHR == 0)
        begin
            scaled = MAG_W'(prod) << SHL;
        end
        else
        begin
            // Round to nearest, ties away from zero, on the magnitude.
            scaled = MAG_W'((prod + PROD_W'(RND)) >> SHR);
        end

        if (dist_neg ^ trig.neg)
        begin
            delta = -$signed({1'b0, scaled});
        end
        else
        begin
            delta = $signed({1'b0, scaled});
        end

        sum = $signed({pos[POS_W-1], pos})
            + $signed({{(POS_W + 1 - DELTA_W){delta[DELTA_W-1]}}, delta});

        if (sum[POS_W] != sum[POS_W-1])
        begin
            pos_next = sum[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        end
        else
        begin
            pos_next = sum[POS_W-1:0];
        end
    end

endmodule
